// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared widths, entry and control types, command codes and the result status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned PRIO_W = 8;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned FILL_W = 7;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t fresh;
  } ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain. On an insert the slot keeps its entry, takes
// the new entry, or takes its left neighbor's entry; on a remove it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  ctrl_t  ctrl,
  input  logic   occupied,
  input  logic   left_after,
  input  entry_t left_entry,
  input  entry_t right_entry,
  output logic   after,
  output entry_t entry
);

  entry_t entry_next;

  // An occupied slot whose priority is not above the new one stays in front.
  assign after = occupied && (entry.prio <= ctrl.fresh.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (after) begin
        entry_next = entry;
      end else if (left_after) begin
        entry_next = ctrl.fresh;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.del) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted queue built as a chain of cells. Lower priority values
// leave first and equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  request   in_valid / in_ready    cmd, priority_req, entry_data
//  result    out_valid / out_ready  status, out_priority, out_data, fill_level
//
// A request is executed in the cycle it is accepted: every cell updates at
// that edge and the result is registered, so one request per cycle is taken
// while the result register is free or being drained.
// A held result blocks new requests until it is taken.
// Reset empties the queue at once; the cell contents are left as they are.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [DATA_W-1:0] entry_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [PRIO_W-1:0] out_priority,
  output logic [DATA_W-1:0] out_data,
  output logic [FILL_W-1:0] fill_level
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  ctrl_t            ctrl;
  status_t          res_status;
  entry_t           res_entry;

  logic   [QUEUE_DEPTH-1:0] occupied;
  logic   [QUEUE_DEPTH-1:0] after;
  entry_t                   entries [QUEUE_DEPTH];

  logic [31:0] count_wide;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctrl.ins        = accept && (cmd == CMD_ENQUEUE) && !full;
  assign ctrl.del        = accept && (cmd == CMD_DEQUEUE) && !empty;
  assign ctrl.fresh.prio = priority_req;
  assign ctrl.fresh.data = entry_data;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      assign occupied[gi] = (CNT_W'(gi) < count);
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occupied[gi]),
        .left_after ((gi == 0) ? 1'b1 : after[(gi == 0) ? 0 : gi - 1]),
        .left_entry (entries[(gi == 0) ? 0 : gi - 1]),
        .right_entry(entries[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
        .after      (after[gi]),
        .entry      (entries[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    res_entry = '0;
    unique case (cmd)
      CMD_ENQUEUE: begin
        res_status = full ? ST_FULL : ST_ENQUEUED;
      end
      CMD_DEQUEUE: begin
        res_status = empty ? ST_EMPTY : ST_DEQUEUED;
        if (!empty) begin
          res_entry = entries[0];
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign count_wide = 32'(count_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= res_status;
      out_priority <= res_entry.prio;
      out_data     <= res_entry.data;
      fill_level   <= count_wide[FILL_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_dequeue_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_DEQUEUE) && !empty) |=> (count == $past(count) - CNT_W'(1)))
    else $error("A dequeue did not remove exactly one entry.");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_ENQUEUE) && full) |=> (full && (status == ST_FULL)))
    else $error("An enqueue to a full queue changed the queue.");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (entries[0].prio <= entries[1].prio))
    else $error("The two front entries are out of order.");

endmodule
